### sv/hbe_pkg.sv
// ============================================================================
// hbe_pkg - shared types for the histogram binning engine
// Operation and status codes, channel payload structs and the command word
// that travels from the classifier to the bin update engine.
// ============================================================================
package hbe_pkg;

    localparam int SAMPLE_W = 16;
    // Wide enough for the largest supported bin store (4096 bins)
    localparam int ADDR_W   = 12;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_INDEX = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_RANGE_MIN   = 2'd0,
        CFG_RANGE_MAX   = 2'd1,
        CFG_BIN_SCALE   = 2'd2,
        CFG_BINS_IN_USE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        op_t                        operation;
        logic signed [SAMPLE_W-1:0] sample;
        logic        [7:0]          bin_index;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] bin_count;
        logic [31:0] total_count;
        logic [16:0] bin_ratio;
    } result_t;

    typedef struct packed {
        logic signed [15:0] range_min;
        logic signed [15:0] range_max;
        logic        [31:0] bin_scale;
        logic        [8:0]  bins_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        CMD_HIT,
        CMD_REJECT,
        CMD_CLEAR,
        CMD_READ,
        CMD_OOB,
        CMD_NOP
    } cmd_kind_t;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        cmd_kind_t kind;
        addr_t     addr;
    } cmd_t;

endpackage

### sv/hbe_ram.sv
// ============================================================================
// hbe_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module hbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/hbe_queue.sv
// ============================================================================
// hbe_queue - small command queue
// Register-based FIFO that decouples the classifier from the update engine.
// ============================================================================
module hbe_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/hbe_front.sv
// ============================================================================
// hbe_front - item classifier
// Two-stage front end: range check, bin scaling multiply and bound checks,
// then index clamping and issue of one command word to the queue.
// ============================================================================
module hbe_front #(
    parameter int NUM_BINS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  hbe_pkg::cfg_t cfg,
    input  logic          take,
    input  hbe_pkg::item_t item,
    output logic          full,
    input  logic          q_full,
    output logic          push,
    output hbe_pkg::cmd_t cmd
);

    localparam int AW = $clog2(NUM_BINS);
    localparam int NW = $clog2(NUM_BINS + 1);

    logic               s1_valid_reg, s1_valid_next;
    hbe_pkg::item_t     s1_item_reg;
    logic               s2_valid_reg, s2_valid_next;
    hbe_pkg::cmd_kind_t s2_kind_reg;
    logic [31:0]        s2_idx_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic [NW-1:0]      s2_n_reg;

    logic               s1_adv;
    logic               s2_free;
    logic [NW-1:0]      n_active;
    logic               in_range;
    logic               read_oob;
    logic [15:0]        diff;
    logic [47:0]        prod;
    hbe_pkg::cmd_kind_t s1_kind;
    logic [AW-1:0]      s2_last;
    logic [AW-1:0]      s2_addr;

    // Clamp bins in use into 1..NUM_BINS
    always_comb
    begin
        if (cfg.bins_in_use == '0)
        begin
            n_active = NW'(1);
        end
        else if (32'(cfg.bins_in_use) > 32'(NUM_BINS))
        begin
            n_active = NW'(NUM_BINS);
        end
        else
        begin
            n_active = NW'(cfg.bins_in_use);
        end
    end

    // Offset from range_min fits 16 unsigned bits whenever the sample is in range
    assign in_range = (s1_item_reg.sample >= cfg.range_min) &&
                      (s1_item_reg.sample <= cfg.range_max);
    assign diff     = s1_item_reg.sample - cfg.range_min;
    assign prod     = 48'(cfg.bin_scale) * 48'(diff);
    assign read_oob = (32'(s1_item_reg.bin_index) >= 32'(n_active));

    always_comb
    begin
        unique case (s1_item_reg.operation)
            hbe_pkg::OP_ADD:   s1_kind = in_range ? hbe_pkg::CMD_HIT : hbe_pkg::CMD_REJECT;
            hbe_pkg::OP_CLEAR: s1_kind = hbe_pkg::CMD_CLEAR;
            hbe_pkg::OP_READ:  s1_kind = read_oob ? hbe_pkg::CMD_OOB : hbe_pkg::CMD_READ;
            hbe_pkg::OP_NOP:   s1_kind = hbe_pkg::CMD_NOP;
        endcase
    end

    // Stage 2: clamp the scaled index to the last active bin
    assign s2_last = AW'(s2_n_reg - NW'(1));

    always_comb
    begin
        if (s2_kind_reg == hbe_pkg::CMD_HIT)
        begin
            s2_addr = (s2_idx_reg >= 32'(s2_n_reg)) ? s2_last : AW'(s2_idx_reg);
        end
        else
        begin
            s2_addr = s2_addr_reg;
        end
    end

    assign cmd.kind = s2_kind_reg;
    assign cmd.addr = hbe_pkg::addr_t'(s2_addr);

    // Pipeline flow
    assign push    = s2_valid_reg && !q_full;
    assign s2_free = !s2_valid_reg || push;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign full    = s1_valid_reg && !s2_free;

    always_comb
    begin
        s1_valid_next = take || (s1_valid_reg && !s1_adv);
        s2_valid_next = s1_adv || (s2_valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= item;
        end
        if (s1_adv)
        begin
            s2_kind_reg <= s1_kind;
            s2_idx_reg  <= prod[47:16];
            s2_addr_reg <= AW'(s1_item_reg.bin_index);
            s2_n_reg    <= n_active;
        end
    end

endmodule

### sv/hbe_back.sv
// ============================================================================
// hbe_back - bin update engine
// Executes queued commands against the bin store: saturating increments,
// reads with a bit-serial ratio divider, and clearing sweeps.
// ============================================================================
module hbe_back #(
    parameter int NUM_BINS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  hbe_pkg::cmd_t    cmd,
    output logic             pop,
    output logic             init_busy,
    output logic             done,
    output hbe_pkg::result_t result
);

    localparam int AW        = $clog2(NUM_BINS);
    localparam int DIV_STEPS = 17;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FETCH,
        S_DIVIDE,
        S_CLEAR
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic [31:0]        total_reg, total_next;
    hbe_pkg::cmd_kind_t kind_reg, kind_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [31:0]        bin_reg, bin_next;
    logic [31:0]        rem_reg, rem_next;
    logic [16:0]        quot_reg, quot_next;
    logic [4:0]         step_reg, step_next;
    logic               done_reg, done_next;
    hbe_pkg::result_t   result_reg, result_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;
    logic [31:0]        bin_inc;
    logic [31:0]        total_inc;
    logic [32:0]        div_shift;
    logic               div_ge;

    hbe_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign bin_inc   = (&ram_rdata) ? ram_rdata : ram_rdata + 32'd1;
    assign total_inc = (&total_reg) ? total_reg : total_reg + 32'd1;

    // One quotient bit a step; the dividend's only nonzero low bit enters first
    assign div_shift = {rem_reg, (step_reg == '0) ? bin_reg[0] : 1'b0};
    assign div_ge    = (div_shift >= {1'b0, total_reg});

    assign pop       = (state_reg == S_IDLE) && !q_empty;
    assign init_busy = (state_reg == S_INIT);
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = '0;
        if (state_reg == S_INIT || state_reg == S_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_FETCH && kind_reg == hbe_pkg::CMD_HIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_reg;
            ram_wdata = bin_inc;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        total_next  = total_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        bin_next    = bin_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            S_INIT,
            S_CLEAR:
            begin
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(NUM_BINS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    kind_next = cmd.kind;
                    addr_next = cmd.addr[AW-1:0];
                    unique case (cmd.kind)
                        hbe_pkg::CMD_HIT,
                        hbe_pkg::CMD_READ:
                        begin
                            state_next = S_FETCH;
                        end
                        hbe_pkg::CMD_REJECT:
                        begin
                            done_next   = 1'b1;
                            result_next = '{hbe_pkg::ST_RANGE, 32'd0, total_reg, 17'd0};
                        end
                        hbe_pkg::CMD_OOB:
                        begin
                            done_next   = 1'b1;
                            result_next = '{hbe_pkg::ST_INDEX, 32'd0, 32'd0, 17'd0};
                        end
                        hbe_pkg::CMD_CLEAR:
                        begin
                            done_next   = 1'b1;
                            result_next = '{hbe_pkg::ST_OK, 32'd0, 32'd0, 17'd0};
                            total_next  = '0;
                            sweep_next  = '0;
                            state_next  = S_CLEAR;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{hbe_pkg::ST_OK, 32'd0, total_reg, 17'd0};
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (kind_reg == hbe_pkg::CMD_HIT)
                begin
                    total_next  = total_inc;
                    done_next   = 1'b1;
                    result_next = '{hbe_pkg::ST_OK, bin_inc, total_inc, 17'd0};
                    state_next  = S_IDLE;
                end
                else if (total_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = '{hbe_pkg::ST_OK, ram_rdata, 32'd0, 17'd0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    bin_next   = ram_rdata;
                    rem_next   = ram_rdata >> 1;
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                rem_next  = div_ge ? 32'(div_shift - {1'b0, total_reg}) : div_shift[31:0];
                quot_next = {quot_reg[15:0], div_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    done_next   = 1'b1;
                    result_next = '{hbe_pkg::ST_OK, bin_reg, total_reg, quot_next};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            sweep_reg  <= '0;
            total_reg  <= '0;
            kind_reg   <= hbe_pkg::CMD_NOP;
            addr_reg   <= '0;
            bin_reg    <= '0;
            rem_reg    <= '0;
            quot_reg   <= '0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            total_reg  <= total_next;
            kind_reg   <= kind_next;
            addr_reg   <= addr_next;
            bin_reg    <= bin_next;
            rem_reg    <= rem_next;
            quot_reg   <= quot_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

endmodule

### sv/histogram_binning_engine.sv
// ============================================================================
// histogram_binning_engine - fixed-range histogram with saturating bins
// Command-style block: add a sample, clear all bins, or read one bin with
// its share of the total as a Q1.16 fraction.
// ============================================================================
//
// Items are taken when start is high and busy is low; every item yields
// exactly one result, shown for one cycle with done high, in item order. The
// receiver cannot stall, so results never wait. After reset the bin store is
// swept to zero, one bin a cycle, and busy stays high until the sweep ends.
// Cost per item is set by the update engine behind the command queue and its
// single-port-pair bin RAM: an add reads the RAM, then increments with
// saturation and writes back; a read fetches the bin and, when the total
// is nonzero, runs the ratio divider, which retires one quotient bit per
// cycle for 17 bits; a rejected add, a bad index or an unused code is
// answered from the idle state; a clear also runs the zeroing sweep. The
// two-stage classifier and the two-entry queue run ahead meanwhile. The
// engine takes no new command until the last one is finished. Configuration
// writes are always taken (cfg_ready is tied high) and must only happen
// while no item is in flight.
//
module histogram_binning_engine #(
    parameter int NUM_BINS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hbe_pkg::item_t       item,
    output logic                 done,
    output hbe_pkg::result_t     result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  hbe_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]          cfg_data
);

    hbe_pkg::cfg_t cfg_reg;
    hbe_pkg::cmd_t q_din;
    hbe_pkg::cmd_t q_dout;

    logic front_full;
    logic init_busy;
    logic take;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // Hold off items while the classifier is backed up or the reset sweep runs
    assign busy      = front_full || init_busy;
    assign take      = start && !busy;
    assign cfg_ready = 1'b1;

    // Configuration registers: each transfer on the config channel lands here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min   <= 16'sd0;
            cfg_reg.range_max   <= 16'sd32767;
            cfg_reg.bin_scale   <= 32'd512;
            cfg_reg.bins_in_use <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hbe_pkg::CFG_RANGE_MIN:   cfg_reg.range_min   <= cfg_data[15:0];
                hbe_pkg::CFG_RANGE_MAX:   cfg_reg.range_max   <= cfg_data[15:0];
                hbe_pkg::CFG_BIN_SCALE:   cfg_reg.bin_scale   <= cfg_data;
                hbe_pkg::CFG_BINS_IN_USE: cfg_reg.bins_in_use <= cfg_data[8:0];
            endcase
        end
    end

    // Front end: range check, scale, clamp, classify
    hbe_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .take   (take),
        .item   (item),
        .full   (front_full),
        .q_full (q_full),
        .push   (q_push),
        .cmd    (q_din)
    );

    // Short queue lets the classifier advance while the update engine works
    hbe_queue #(
        .T     (hbe_pkg::cmd_t),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // Back end: bin store, total counter, ratio divider, result register
    hbe_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .cmd       (q_dout),
        .pop       (q_pop),
        .init_busy (init_busy),
        .done      (done),
        .result    (result)
    );

endmodule

### test/tb_top.sv
// ============================================================================
// tb_top - self-checking bench for the histogram binning engine
// Sends add, clear, read and no-op commands through the start/busy port and
// keeps a private histogram that mirrors the engine. Each accepted command
// yields one predicted result. The monitor compares every done strobe with
// the oldest prediction, field by field. Register settings change only
// while the engine is idle, and they cover the extremes as well as random
// windows.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hbe_pkg::*;

    localparam int NUM_BINS     = 256;
    localparam int BIN_W        = $clog2(NUM_BINS);
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES = 8;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    item_t       item      = '0;
    logic        done;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_RANGE_MIN;
    logic [31:0] cfg_data  = '0;

    histogram_binning_engine #(
        .NUM_BINS (NUM_BINS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Mirror of the engine: bin store, total and register copies
    // ------------------------------------------------------------------------
    logic [31:0] bin_tally [NUM_BINS];
    logic [31:0] sample_sum = '0;
    cfg_t        setting    = '{range_min: 16'sd0, range_max: 16'sh7fff,
                                bin_scale: 32'd512, bins_in_use: 9'd256};

    item_t   cmd_q    [$];   // commands waiting for the driver
    result_t result_q [$];   // predicted results, oldest first

    int gap_max    = 0;      // longest idle gap the driver may insert
    int gap_left   = 0;
    int err_cnt    = 0;
    int cycle_cnt  = 0;
    int n_items    = 0;
    int n_results  = 0;
    int n_settings = 1;
    int n_hit = 0, n_reject = 0, n_clear = 0, n_read = 0, n_oob = 0, n_nop = 0;

    initial
    begin
        foreach (bin_tally[i])
            bin_tally[i] = '0;
    end

    function automatic logic [31:0] sat_next(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Zero counts as one bin, anything past the built store as the full store
    function automatic int active_bins();
        int n;
        n = int'(setting.bins_in_use);
        if (n < 1)
            n = 1;
        if (n > NUM_BINS)
            n = NUM_BINS;
        return n;
    endfunction

    // Apply one command to the mirror and return the result it must produce
    function automatic result_t histogram_update(item_t it);
        result_t          res;
        int               n;
        int               x;
        int               lo;
        int               hi;
        longint unsigned  pos;
        logic [BIN_W-1:0] slot;
        logic [47:0]      quot;
        res        = '0;
        res.status = ST_OK;
        n          = active_bins();
        lo         = int'(setting.range_min);
        hi         = int'(setting.range_max);
        case (it.operation)
            OP_ADD:
            begin
                x = int'(it.sample);
                if (x < lo || x > hi)
                begin
                    res.status      = ST_RANGE;
                    res.total_count = sample_sum;
                    n_reject++;
                end
                else
                begin
                    // Exact product, then clamp to the last active bin
                    pos = (64'(setting.bin_scale) * 64'(x - lo)) >> 16;
                    if (pos >= longint'(n))
                        pos = 64'(n - 1);
                    slot            = BIN_W'(pos);
                    bin_tally[slot] = sat_next(bin_tally[slot]);
                    sample_sum      = sat_next(sample_sum);
                    res.bin_count   = bin_tally[slot];
                    res.total_count = sample_sum;
                    n_hit++;
                end
            end
            OP_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                sample_sum = '0;
                n_clear++;
            end
            OP_READ:
            begin
                if (int'(it.bin_index) >= n)
                begin
                    res.status = ST_INDEX;
                    n_oob++;
                end
                else
                begin
                    res.bin_count   = bin_tally[it.bin_index];
                    res.total_count = sample_sum;
                    if (sample_sum != 0)
                    begin
                        quot = {bin_tally[it.bin_index], 16'h0000} / {16'h0000, sample_sum};
                        res.bin_ratio = (quot > 48'd65536) ? 17'h10000 : quot[16:0];
                    end
                    n_read++;
                end
            end
            default:
            begin
                res.total_count = sample_sum;
                n_nop++;
            end
        endcase
        return res;
    endfunction

    function automatic item_t make_item(op_t op, logic [15:0] s, logic [7:0] idx);
        item_t it;
        it.operation = op;
        it.sample    = s;
        it.bin_index = idx;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued commands, predict each transfer as it happens
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left = 0;
        end
        else
        begin
            // Transfer: start high and busy low at this edge
            if (start && !busy)
            begin
                result_q.push_back(histogram_update(item));
                n_items++;
                gap_left = (gap_max == 0 || $urandom_range(0, 2) == 0) ?
                           0 : int'($urandom_range(1, gap_max));
            end
            // Hold the current command while busy; otherwise advance
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_q.size() != 0)
                begin
                    item  <= cmd_q.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every done strobe must match the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (result_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: expected no result,", $time,
                         " got status %0d bin %0d total %0d ratio %0d",
                         result.status, result.bin_count, result.total_count,
                         result.bin_ratio);
            end
            else if (result.status      != result_q[0].status      ||
                     result.bin_count   != result_q[0].bin_count   ||
                     result.total_count != result_q[0].total_count ||
                     result.bin_ratio   != result_q[0].bin_ratio)
            begin
                err_cnt++;
                $display("%0t: expected status %0d bin %0d total %0d ratio %0d,",
                         $time, result_q[0].status, result_q[0].bin_count,
                         result_q[0].total_count, result_q[0].bin_ratio,
                         " got status %0d bin %0d total %0d ratio %0d",
                         result.status, result.bin_count, result.total_count,
                         result.bin_ratio);
                void'(result_q.pop_front());
            end
            else
            begin
                void'(result_q.pop_front());
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("Mismatches found");
            $finish;
        end
    end

    // Wait until every queued command has been sent and every result has
    // come back, then let the engine settle.
    task automatic wait_drained();
        while (cmd_q.size() != 0 || start || busy || result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register transfer; lower valid for a cycle before returning
    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_RANGE_MIN:   setting.range_min   = data[15:0];
            CFG_RANGE_MAX:   setting.range_max   = data[15:0];
            CFG_BIN_SCALE:   setting.bin_scale   = data;
            CFG_BINS_IN_USE: setting.bins_in_use = data[8:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          phase;
        int          k;
        int          sel;
        int          a;
        int          b;
        int          lo;
        int          hi;
        int          nb;
        int          n_eff;
        int          x;
        longint      fit;
        logic [31:0] scale_v;
        item_t       it;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: 0..32767 over 256 bins, 128 samples a bin
        gap_max = 0;
        cmd_q.push_back(make_item(OP_READ,  16'h0000, 8'd0));    // empty: zero ratio
        cmd_q.push_back(make_item(OP_ADD,   16'h0000, 8'd0));    // lowest accepted
        cmd_q.push_back(make_item(OP_ADD,   16'h7FFF, 8'd0));    // highest, last bin
        cmd_q.push_back(make_item(OP_ADD,   16'hFFFF, 8'd0));    // just below range
        cmd_q.push_back(make_item(OP_ADD,   16'h8000, 8'd0));    // most negative
        cmd_q.push_back(make_item(OP_ADD,   16'h0005, 8'd0));
        cmd_q.push_back(make_item(OP_READ,  16'h0000, 8'd0));
        cmd_q.push_back(make_item(OP_READ,  16'h0000, 8'd255));
        cmd_q.push_back(make_item(OP_NOP,   16'h1234, 8'd9));
        cmd_q.push_back(make_item(OP_CLEAR, 16'h0000, 8'd0));
        cmd_q.push_back(make_item(OP_READ,  16'h0000, 8'd255));  // after clear
        wait_drained();

        // Full signed window, maximum scale: huge indexes clamp, few bins
        gap_max = 9;
        write_reg(CFG_BINS_IN_USE, 32'd4);
        write_reg(CFG_RANGE_MIN,   32'h0000_8000);
        write_reg(CFG_RANGE_MAX,   32'h0000_7FFF);
        write_reg(CFG_BIN_SCALE,   32'hFFFF_FFFF);
        n_settings++;
        cmd_q.push_back(make_item(OP_ADD,  16'h7FFF, 8'd0));
        cmd_q.push_back(make_item(OP_ADD,  16'h8000, 8'd0));
        cmd_q.push_back(make_item(OP_ADD,  16'h8001, 8'd0));
        cmd_q.push_back(make_item(OP_READ, 16'h0000, 8'd3));
        cmd_q.push_back(make_item(OP_READ, 16'h0000, 8'd4));      // out of bounds
        wait_drained();

        // Zero bins in use, inverted window: every add is rejected
        write_reg(CFG_BINS_IN_USE, 32'd0);
        write_reg(CFG_RANGE_MIN,   32'd100);
        write_reg(CFG_RANGE_MAX,   32'hFFFF_FF9C);
        write_reg(CFG_BIN_SCALE,   32'd0);
        n_settings++;
        cmd_q.push_back(make_item(OP_ADD,  16'h0000, 8'd0));
        cmd_q.push_back(make_item(OP_ADD,  16'h0064, 8'd0));
        cmd_q.push_back(make_item(OP_READ, 16'h0000, 8'd0));
        cmd_q.push_back(make_item(OP_READ, 16'h0000, 8'd1));      // one bin only
        wait_drained();

        // Single-value window, bins past the built store, zero scale
        write_reg(CFG_BINS_IN_USE, 32'h1FF);
        write_reg(CFG_RANGE_MIN,   32'd5);
        write_reg(CFG_RANGE_MAX,   32'd5);
        n_settings++;
        cmd_q.push_back(make_item(OP_ADD,  16'h0005, 8'd0));
        cmd_q.push_back(make_item(OP_ADD,  16'h0004, 8'd0));
        cmd_q.push_back(make_item(OP_ADD,  16'h0006, 8'd0));
        cmd_q.push_back(make_item(OP_READ, 16'h0000, 8'd255));
        wait_drained();

        // Random phases: a fresh setting each, gaps on in every other phase
        for (phase = 0; phase < 12; phase++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                nb = $urandom_range(1, NUM_BINS);
            else if (sel < 6)
                nb = NUM_BINS;
            else if (sel == 6)
                nb = 1;
            else if (sel == 7)
                nb = 0;
            else if (sel == 8)
                nb = $urandom_range(NUM_BINS + 1, 511);
            else
                nb = $urandom_range(2, 16);

            a  = int'($urandom_range(0, 65535)) - 32768;
            b  = int'($urandom_range(0, 65535)) - 32768;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                lo = -32768;
                hi = 32767;
            end
            else if (sel == 8)
                hi = lo;

            // Scale that spreads the window over the active bins, or an extreme
            n_eff = (nb == 0) ? 1 : (nb > NUM_BINS) ? NUM_BINS : nb;
            fit   = (longint'(n_eff) << 16) / (hi - lo + 1);
            sel   = $urandom_range(0, 9);
            if (sel < 6)
                scale_v = 32'(fit) + $urandom_range(0, 255);
            else if (sel == 6)
                scale_v = $urandom();
            else if (sel == 7)
                scale_v = '1;
            else if (sel == 8)
                scale_v = '0;
            else
                scale_v = $urandom_range(0, 65535);

            // Now and then swap the bounds so the window is empty
            if ($urandom_range(0, 11) == 0 && lo != hi)
            begin
                a  = lo;
                lo = hi;
                hi = a;
            end

            // Unused upper data bits carry noise; the engine must drop them
            write_reg(CFG_RANGE_MIN,   {16'($urandom()), 16'(lo)});
            write_reg(CFG_RANGE_MAX,   {16'($urandom()), 16'(hi)});
            write_reg(CFG_BIN_SCALE,   scale_v);
            write_reg(CFG_BINS_IN_USE, {23'($urandom()), 9'(nb)});
            n_settings++;
            gap_max = (phase % 2 == 1) ? 9 : 0;

            lo = int'(setting.range_min);
            hi = int'(setting.range_max);
            for (k = 0; k < 79; k++)
            begin
                // Hold the sender mid-phase until every result is back
                if (phase % 3 == 1 && k == 40)
                    wait_drained();
                it.sample    = 16'($urandom());
                it.bin_index = 8'($urandom());
                sel = $urandom_range(0, 99);
                if (sel < 68)
                begin
                    it.operation = OP_ADD;
                    sel = $urandom_range(0, 99);
                    if (lo <= hi && sel < 75)
                    begin
                        x = lo + int'($urandom_range(0, hi - lo));
                        it.sample = 16'(x);
                    end
                    else if (sel < 87)
                    begin
                        case ($urandom_range(0, 3))
                            0:       it.sample = 16'(lo - 1);
                            1:       it.sample = 16'(lo);
                            2:       it.sample = 16'(hi);
                            default: it.sample = 16'(hi + 1);
                        endcase
                    end
                end
                else if (sel < 92)
                begin
                    it.operation = OP_READ;
                    if ($urandom_range(0, 3) != 0)
                        it.bin_index = 8'($urandom_range(0, active_bins() - 1));
                end
                else if (sel < 95)
                    it.operation = OP_NOP;
                else
                    it.operation = OP_CLEAR;
                cmd_q.push_back(it);
            end
            wait_drained();
        end

        $display("Ran %0d commands under %0d register settings:", n_items, n_settings,
                 " %0d counted adds, %0d rejected adds, %0d clears, %0d no-ops",
                 n_hit, n_reject, n_clear, n_nop);
        $display("Bin reads: %0d in bounds, %0d out of bounds; %0d results compared",
                 n_read, n_oob, n_results);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
